// ===== sv/iel_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package iel_pkg;

  localparam int CAPACITY = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 16;
  localparam int OP_W     = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_DUMP   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_RESP,
    ST_DUMP_RD,
    ST_DUMP_OUT
  } state_t;

  typedef struct packed {
    logic                     ok;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] element;
    logic                     element_valid;
    logic                     last;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== sv/iel_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iel_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/iel_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module iel_seq (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [iel_pkg::OP_W-1:0]         in_op,
  input  wire logic signed [iel_pkg::POS_W-1:0] in_position,
  input  wire logic signed [iel_pkg::DATA_W-1:0] in_value,
  output logic                                  res_valid,
  input  wire logic                             res_ready,
  output iel_pkg::res_t                         res,
  output iel_pkg::mem_req_t                     mem_req,
  input  wire logic [iel_pkg::DATA_W-1:0]       mem_rdata
);
  import iel_pkg::*;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      pos_r, pos_nxt;
  logic [CW-1:0]      fill_r, fill_nxt;
  logic [DATA_W-1:0]  val_r, val_nxt;
  logic               ins_r, ins_nxt;
  logic               ok_r, ok_nxt;

  logic [CW-1:0]      sum;       // shared index stepper
  logic [POS_W-1:0]   pos_u;
  logic               pos_neg;
  logic               ins_ok;
  logic               er_ok;
  logic               accept;

  assign pos_u   = in_position;
  assign pos_neg = in_position[POS_W-1];
  assign ins_ok  = !pos_neg && (pos_u <= POS_W'(fill_r)) && (fill_r != CW'(CAPACITY));
  assign er_ok   = !pos_neg && (pos_u < POS_W'(fill_r));
  assign accept  = in_valid && in_ready;

  // insert walks down, erase and dump walk up
  assign sum = ins_r ? (idx_r - CW'(1)) : (idx_r + CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    ins_r <= ins_nxt;
    ok_r  <= ok_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    fill_nxt  = fill_r;
    val_nxt   = val_r;
    ins_nxt   = ins_r;
    ok_nxt    = ok_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    res       = '{ok: ok_r, count: COUNT_W'(fill_r), element: '0,
                  element_valid: 1'b0, last: 1'b1};
    mem_req   = '{we: 1'b0, waddr: idx_r[AW-1:0], wdata: mem_rdata,
                  raddr: sum[AW-1:0]};

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          pos_nxt = CW'(in_position);
          val_nxt = in_value;
          ins_nxt = 1'b0;
          ok_nxt  = 1'b0;
          state_nxt = ST_RESP;
          unique case (in_op)
            OP_INSERT: begin
              ins_nxt = 1'b1;
              if (ins_ok) begin
                ok_nxt   = 1'b1;
                fill_nxt = fill_r + CW'(1);
                idx_nxt  = fill_r;
                state_nxt = (CW'(in_position) == fill_r) ? ST_PUT : ST_SHIFT_RD;
              end
            end
            OP_ERASE: begin
              if (er_ok) begin
                ok_nxt   = 1'b1;
                fill_nxt = fill_r - CW'(1);
                idx_nxt  = CW'(in_position);
                // erasing the tail needs no move
                state_nxt = (CW'(in_position) == fill_r - CW'(1)) ? ST_RESP : ST_SHIFT_RD;
              end
            end
            OP_DUMP: begin
              ok_nxt  = 1'b1;
              idx_nxt = '0;
              state_nxt = (fill_r == '0) ? ST_RESP : ST_DUMP_RD;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      ST_SHIFT_RD: begin
        state_nxt = ST_SHIFT_WR;
      end

      ST_SHIFT_WR: begin
        mem_req.we = 1'b1;
        idx_nxt    = sum;
        if (ins_r) begin
          state_nxt = (sum == pos_r) ? ST_PUT : ST_SHIFT_RD;
        end else begin
          state_nxt = (sum == fill_r) ? ST_RESP : ST_SHIFT_RD;
        end
      end

      ST_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos_r[AW-1:0];
        mem_req.wdata = val_r;
        state_nxt     = ST_RESP;
      end

      ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_DUMP_RD: begin
        mem_req.raddr = idx_r[AW-1:0];
        state_nxt     = ST_DUMP_OUT;
      end

      ST_DUMP_OUT: begin
        mem_req.raddr     = idx_r[AW-1:0];
        res_valid         = 1'b1;
        res.element       = mem_rdata;
        res.element_valid = 1'b1;
        res.last          = (sum == fill_r);
        if (res_ready) begin
          idx_nxt   = sum;
          state_nxt = (sum == fill_r) ? ST_IDLE : ST_DUMP_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/indexed_insert_erase_list.sv =====
// Indexed insert/erase list of signed 32-bit words, up to 64 entries.
// Input channel (in_valid/in_ready): op, position, value. op insert puts
// value at position 0..count, erase removes position 0..count-1, dump
// emits every stored word in order; anything else returns ok=0.
// Result channel (out_valid/out_ready): ok, count, element, element_valid,
// last. Insert, erase and rejects give one item with last=1; a dump gives
// one item per element, last on the final one, or a single empty item.
// Timing: the store is a single-port-write, registered-read RAM, and every
// move of an entry goes through it: insert and erase shift each entry past
// the position with a read and then a write, and a dump reads each element
// before it emits it. in_ready is high only while idle, so the next item
// is taken in the cycle after the sequencer hands its last result on.
// Results go through an output register, so the next item can be taken
// while a result still waits on a stalled receiver; the sequencer simply
// holds when the output register is occupied and not being drained.
// Reset (rst_n low, synchronous) empties the list; the RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module indexed_insert_erase_list (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [iel_pkg::OP_W-1:0]          in_op,
  input  wire logic signed [iel_pkg::POS_W-1:0]  in_position,
  input  wire logic signed [iel_pkg::DATA_W-1:0] in_value,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_ok,
  output logic [iel_pkg::COUNT_W-1:0]            out_count,
  output logic signed [iel_pkg::DATA_W-1:0]      out_element,
  output logic                                   out_element_valid,
  output logic                                   out_last
);
  import iel_pkg::*;

  res_t              res;
  logic              res_valid;
  logic              res_ready;
  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;

  res_t              out_r;
  logic              out_valid_r;

  iel_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_position (in_position),
    .in_value    (in_value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata)
  );

  iel_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_r.ok;
  assign out_count         = out_r.count;
  assign out_element       = out_r.element;
  assign out_element_valid = out_r.element_valid;
  assign out_last          = out_r.last;

endmodule
`default_nettype wire
